### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising edge of clk outside reset.
`define WFA_ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("property check failed");
// Checks that a condition is never true outside reset.
`define WFA_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define WFA_ASSERT_PROP(label, clk, rst, prop)
`define WFA_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### rtl/core/wfa_pkg.sv
// Types and constants shared by the worst-fit allocator modules.
`timescale 1ns / 1ps
`default_nettype none
package wfa_pkg;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_ALLOC = 2'd2
  } wfa_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_ADDED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } wfa_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic do_clear;
    logic do_add;
    logic do_full;
    logic count_req;
    logic do_nofit;
    logic scan_start;
    logic scan_step;
    logic do_update;
    logic publish;
  } wfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    wfa_op_t op;
    logic    full;
    logic    empty;
    logic    scan_done;
  } wfa_stat_t;

endpackage
`default_nettype wire

### rtl/core/wfa_ctrl.sv
// Controller state machine of the worst-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
module wfa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [wfa_pkg::OP_W-1:0]  operation,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output wfa_pkg::wfa_cmd_t         cmd,
  input  wfa_pkg::wfa_stat_t        stat
);
  import wfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_UPDATE   = 5'b01000,
    S_PUBLISH  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   op_known;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign op_known = operation inside {OP_CLEAR, OP_ADD, OP_ALLOC};

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        // Unused operation codes are taken and dropped without a result.
        if (in_valid && op_known) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_PUBLISH;
        case (stat.op)
          OP_CLEAR: cmd.do_clear = 1'b1;
          OP_ADD: begin
            if (stat.full) cmd.do_full = 1'b1;
            else cmd.do_add = 1'b1;
          end
          OP_ALLOC: begin
            cmd.count_req = 1'b1;
            if (stat.empty) begin
              cmd.do_nofit = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: cmd.do_clear = 1'b1;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.do_update = 1'b1;
        state_next    = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/wfa_datapath.sv
// Datapath of the worst-fit allocator: block table, counters, scan and result.
`timescale 1ns / 1ps
`default_nettype none
module wfa_datapath #(
  parameter int MAX_BLOCKS = 256,
  parameter int CNT_W      = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wfa_pkg::OP_W-1:0]      operation,
  input  logic [wfa_pkg::SIZE_W-1:0]    size,
  input  wfa_pkg::wfa_cmd_t             cmd,
  output wfa_pkg::wfa_stat_t            stat,
  output logic [wfa_pkg::STATUS_W-1:0]  status,
  output logic [CNT_W-1:0]              block_id,
  output logic [wfa_pkg::SIZE_W-1:0]    space_before,
  output logic [wfa_pkg::SIZE_W-1:0]    space_left,
  output logic [wfa_pkg::REQ_W-1:0]     request_number
);
  import wfa_pkg::*;

  localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [SIZE_W-1:0] mem [MAX_BLOCKS];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SIZE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [SIZE_W-1:0] rd_data;

  wfa_op_t           op_q;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  block_count;
  logic [REQ_W-1:0]  request_count;

  logic [CNT_W-1:0]  scan_addr;
  logic              issue;
  logic              cmp_valid;
  logic [ADDR_W-1:0] cmp_idx;
  logic [ADDR_W-1:0] best_idx;
  logic [SIZE_W-1:0] best_space;
  logic              take;
  logic              fit;
  logic [SIZE_W-1:0] remain;

  wfa_status_t       res_status;
  logic [CNT_W-1:0]  res_id;
  logic [SIZE_W-1:0] res_before;
  logic [SIZE_W-1:0] res_left;

  assign stat.op        = op_q;
  assign stat.full      = (block_count == CNT_W'(MAX_BLOCKS));
  assign stat.empty     = (block_count == '0);
  assign stat.scan_done = cmp_valid && (CNT_W'(cmp_idx) == block_count - CNT_W'(1));

  assign issue   = cmd.scan_step && (scan_addr < block_count);
  assign rd_addr = cmd.scan_start ? '0 : scan_addr[ADDR_W-1:0];

  // First entry seeds the maximum; a later one must be strictly larger.
  assign take   = cmd.scan_step && cmp_valid &&
                  ((cmp_idx == '0) || (rd_data > best_space));
  assign fit    = (best_space >= size_q);
  assign remain = best_space - size_q;

  assign wr_en   = cmd.do_add || (cmd.do_update && fit);
  assign wr_addr = cmd.do_add ? block_count[ADDR_W-1:0] : best_idx;
  assign wr_data = cmd.do_add ? size_q : remain;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= '0;
      request_count <= '0;
      cmp_valid     <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        block_count   <= '0;
        request_count <= '0;
      end
      if (cmd.do_add) block_count <= block_count + CNT_W'(1);
      if (cmd.count_req && (request_count != {REQ_W{1'b1}})) begin
        request_count <= request_count + REQ_W'(1);
      end
      cmp_valid <= cmd.scan_start || issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q   <= wfa_op_t'(operation);
      size_q <= size;
    end
    if (cmd.scan_start) begin
      scan_addr <= CNT_W'(1);
      cmp_idx   <= '0;
    end else if (issue) begin
      scan_addr <= scan_addr + CNT_W'(1);
      cmp_idx   <= scan_addr[ADDR_W-1:0];
    end
    if (take) begin
      best_idx   <= cmp_idx;
      best_space <= rd_data;
    end
    if (cmd.do_clear) begin
      res_status <= ST_CLEARED;
      res_id     <= '0;
      res_before <= '0;
      res_left   <= '0;
    end
    if (cmd.do_full || cmd.do_nofit || (cmd.do_update && !fit)) begin
      res_status <= cmd.do_full ? ST_FULL : ST_NO_FIT;
      res_id     <= '0;
      res_before <= '0;
      res_left   <= '0;
    end
    if (cmd.do_add) begin
      res_status <= ST_ADDED;
      res_id     <= block_count + CNT_W'(1);
      res_before <= '0;
      res_left   <= '0;
    end
    if (cmd.do_update && fit) begin
      res_status <= ST_ALLOCATED;
      res_id     <= CNT_W'(best_idx) + CNT_W'(1);
      res_before <= best_space;
      res_left   <= remain;
    end
    if (cmd.publish) begin
      status       <= res_status;
      block_id     <= res_id;
      space_before <= res_before;
      space_left   <= res_left;
      if (res_status == ST_ALLOCATED || res_status == ST_NO_FIT) begin
        request_number <= request_count;
      end else begin
        request_number <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/worst_fit_allocator_core.sv
// Top level of the worst-fit allocator core.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// The core keeps a table of up to MAX_BLOCKS free blocks in a simple dual-port
// style memory and serves one transaction at a time. A clear transaction
// empties the table and zeroes the request counter; an add transaction
// appends a block whose id is its position plus one, or reports the table
// full; an allocate transaction finds the block with the most remaining
// space (the lowest id wins a tie), shrinks it by the request when it fits,
// and otherwise reports no fit. Unused operation code 3 is taken and
// dropped with no result. Clear and add go from dispatch straight to the
// result; an allocate on a non-empty table first scans the table through
// one registered memory read port, one entry per cycle, and then updates
// the block it chose. A new input transaction is taken as soon as the
// previous result has been loaded into the output register, even if that
// result has not yet been taken downstream. There is no clearing pass
// after reset: the block count alone tells which table entries hold data.
module worst_fit_allocator_core #(
  parameter int MAX_BLOCKS = 256,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wfa_pkg::OP_W-1:0]      operation,
  input  logic [wfa_pkg::SIZE_W-1:0]    size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wfa_pkg::STATUS_W-1:0]  status,
  output logic [CNT_W-1:0]              block_id,
  output logic [wfa_pkg::SIZE_W-1:0]    space_before,
  output logic [wfa_pkg::SIZE_W-1:0]    space_left,
  output logic [wfa_pkg::REQ_W-1:0]     request_number
);
  import wfa_pkg::*;

  wfa_cmd_t  cmd;
  wfa_stat_t stat;

  // The controller sequences each transaction and owns both handshakes.
  wfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the table, the counters, the scan and the result.
  wfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .size           (size),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .block_id       (block_id),
    .space_before   (space_before),
    .space_left     (space_left),
    .request_number (request_number)
  );

  // Only one table or result action is issued in any cycle.
  `WFA_ASSERT_PROP(a_one_action, clk, rst, $onehot0({cmd.do_clear, cmd.do_add, cmd.do_full, cmd.do_nofit, cmd.scan_start, cmd.do_update, cmd.publish}))
  // A no-fit result never names a block or a space.
  `WFA_ASSERT_PROP(a_nofit_zero, clk, rst, (out_valid && status == ST_NO_FIT) |-> (block_id == '0 && space_before == '0 && space_left == '0))
  // An allocation names a real block and never grows it.
  `WFA_ASSERT_PROP(a_alloc_shrinks, clk, rst, (out_valid && status == ST_ALLOCATED) |-> (block_id != '0 && space_left <= space_before && request_number != '0))
  // A new result is loaded only when the output register is free.
  `WFA_ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.publish && out_valid && !out_ready)

endmodule
`default_nettype wire

### sim/wfa_reply_checker.sv
// Reply checker for the worst-fit allocator core: predicts every reply and compares it.
`timescale 1ns / 1ps
module wfa_reply_checker #(
  parameter int MAX_BLOCKS = 256,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [wfa_pkg::OP_W-1:0]      operation,
  input  logic [wfa_pkg::SIZE_W-1:0]    size,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [wfa_pkg::STATUS_W-1:0]  status,
  input  logic [CNT_W-1:0]              block_id,
  input  logic [wfa_pkg::SIZE_W-1:0]    space_before,
  input  logic [wfa_pkg::SIZE_W-1:0]    space_left,
  input  logic [wfa_pkg::REQ_W-1:0]     request_number,
  output int unsigned                   mismatches,
  output int unsigned                   replies_due
);
  import wfa_pkg::*;

  typedef struct {
    wfa_status_t       status;
    logic [CNT_W-1:0]  block_id;
    logic [SIZE_W-1:0] prior;
    logic [SIZE_W-1:0] left;
    logic [REQ_W-1:0]  req;
  } alloc_reply_t;

  alloc_reply_t      predicted_replies[$];
  logic [SIZE_W-1:0] free_space[MAX_BLOCKS];
  int unsigned       blocks_held;
  logic [REQ_W-1:0]  alloc_requests;

  initial begin
    mismatches  = 0;
    replies_due = 0;
  end

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endfunction

  // Applies one accepted transaction to the table and queues the reply it causes.
  function automatic void serve_transaction(input logic [OP_W-1:0] op,
                                            input logic [SIZE_W-1:0] req_size);
    alloc_reply_t      reply;
    int unsigned       best;
    logic [SIZE_W-1:0] best_space;
    reply = '{ST_CLEARED, '0, '0, '0, '0};
    case (op)
      OP_CLEAR: begin
        blocks_held    = 0;
        alloc_requests = '0;
      end
      OP_ADD: begin
        if (blocks_held >= MAX_BLOCKS) begin
          reply.status = ST_FULL;
        end else begin
          free_space[blocks_held] = req_size;
          blocks_held++;
          reply.status   = ST_ADDED;
          reply.block_id = CNT_W'(blocks_held);
        end
      end
      OP_ALLOC: begin
        if (alloc_requests != '1) alloc_requests++;
        reply.status = ST_NO_FIT;
        reply.req    = alloc_requests;
        if (blocks_held != 0) begin
          best       = 0;
          best_space = free_space[0];
          // Strictly greater, so the lowest id keeps a tie.
          for (int k = 1; k < blocks_held; k++) begin
            if (free_space[k] > best_space) begin
              best       = k;
              best_space = free_space[k];
            end
          end
          if (best_space >= req_size) begin
            free_space[best] = best_space - req_size;
            reply.status     = ST_ALLOCATED;
            reply.block_id   = CNT_W'(best + 1);
            reply.prior      = best_space;
            reply.left       = best_space - req_size;
          end
        end
      end
      default: return;  // The unused code is dropped without a reply.
    endcase
    predicted_replies.push_back(reply);
  endfunction

  function automatic void check_reply();
    alloc_reply_t want;
    if (predicted_replies.size() == 0) begin
      mismatches++;
      $error("reply with no transaction waiting: status %0d, block_id %0d",
             status, block_id);
    end else begin
      want = predicted_replies.pop_front();
      compare_field("status", want.status, status);
      compare_field("block_id", want.block_id, block_id);
      compare_field("space_before", want.prior, space_before);
      compare_field("space_left", want.left, space_left);
      compare_field("request_number", want.req, request_number);
    end
  endfunction

  // The block's outputs change on the nonblocking update, so the values read
  // here are the ones present at the edge.
  always @(posedge clk) begin
    if (rst) begin
      blocks_held    = 0;
      alloc_requests = '0;
      predicted_replies.delete();
    end else begin
      if (in_valid && in_ready) serve_transaction(operation, size);
      if (out_valid && out_ready) check_reply();
    end
    replies_due = predicted_replies.size();
  end

endmodule

### sim/tb_worst_fit_allocator_core.sv
// Testbench top for the worst-fit allocator core: stimulus, pacing and the verdict.
`timescale 1ns / 1ps
module tb_worst_fit_allocator_core;
  import wfa_pkg::*;

  localparam int MAX_BLOCKS = 256;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Operation code 3 has no meaning; the core must swallow it without a reply.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A full-table allocate is the longest wait, and stalls on both sides lengthen
  // it; a run of quiet cycles as long as STALL_LIMIT means the core is stuck.
  localparam int STALL_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 360;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation = '0;
  logic [SIZE_W-1:0] size      = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]  block_id;
  logic [SIZE_W-1:0] space_before;
  logic [SIZE_W-1:0] space_left;
  logic [REQ_W-1:0]  request_number;

  int unsigned mismatches;
  int unsigned replies_due;

  // Pacing knobs: percentage of cycles in which the sender holds off, and in
  // which the receiver refuses a reply.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  int send_pcts[4]  = '{0, 49, 0, 25};
  int stall_pcts[4] = '{0, 0, 49, 25};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  worst_fit_allocator_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .size           (size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .block_id       (block_id),
    .space_before   (space_before),
    .space_left     (space_left),
    .request_number (request_number)
  );

  wfa_reply_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .size           (size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .block_id       (block_id),
    .space_before   (space_before),
    .space_left     (space_left),
    .request_number (request_number),
    .mismatches     (mismatches),
    .replies_due    (replies_due)
  );

  // The receiver decides once per cycle, at the falling edge, whether it
  // takes a reply at the next rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: any transaction on either channel proves the core is alive.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one input transaction. It is entered and left at a falling edge.
  // Sender gaps drop valid first; once raised, valid and the payload stay
  // put until the core accepts. Back-to-back transactions keep valid high
  // without lowering it in between.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] sz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    size      <= sz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Block sizes by flavor: tiny values give many ties, full range gives a
  // spread, and the extremes test the ends of the field.
  function automatic logic [SIZE_W-1:0] block_size(input int flavor);
    case (flavor)
      0:       return SIZE_W'($urandom_range(0, 15));
      1:       return SIZE_W'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return SIZE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Request sizes are scaled to the block flavor so that fits and no-fits
  // both happen often.
  function automatic logic [SIZE_W-1:0] request_size(input int flavor);
    case (flavor)
      0:       return SIZE_W'($urandom_range(0, 20));
      1:       return ($urandom_range(0, 99) < 70) ? SIZE_W'($urandom_range(0, 20000))
                                                   : SIZE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return SIZE_W'(1);
          default: return SIZE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Hand-picked opening: empty-table requests, zero and maximum blocks, a
  // tie between two equal blocks, exact fits, a zero-size request, a no-fit,
  // the unused code, and requests right after a clear.
  task automatic directed_items();
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_ALLOC, 16'hFFFF);
    send_item(OP_ADD, 16'd0);
    send_item(OP_ADD, 16'hFFFF);
    send_item(OP_ADD, 16'hFFFF);
    send_item(OP_ADD, 16'd100);
    send_item(OP_ALLOC, 16'hFFFF);
    send_item(OP_ALLOC, 16'hFFFF);
    send_item(OP_ALLOC, 16'd1);
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_ALLOC, 16'd200);
    send_item(OP_UNUSED, 16'hA5A5);
    send_item(OP_ADD, 16'h5A5A);
    send_item(OP_UNUSED, 16'h0000);
    send_item(OP_ALLOC, 16'h5A5A);
    send_item(OP_CLEAR, 16'hFFFF);
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_ADD, 16'd7);
    send_item(OP_CLEAR, 16'd0);
  endtask

  // The normal use of the core: clear, load a table, then serve requests
  // with an occasional add mixed in. A full-table sequence loads past the
  // limit so that the refused adds and the longest scans are exercised.
  task automatic allocation_sequence(input bit fill_table);
    int flavor;
    int n_blocks;
    int n_requests;
    flavor     = $urandom_range(0, 2);
    n_blocks   = fill_table ? MAX_BLOCKS + $urandom_range(1, 3) : $urandom_range(1, 12);
    n_requests = fill_table ? $urandom_range(3, 6) : $urandom_range(1, 16);
    send_item(OP_CLEAR, SIZE_W'($urandom));
    repeat (n_blocks) send_item(OP_ADD, block_size(flavor));
    repeat (n_requests) begin
      if ($urandom_range(0, 99) < 15)
        send_item(OP_ADD, block_size(flavor));
      else
        send_item(OP_ALLOC, request_size(flavor));
    end
  endtask

  // Noise: any code, any size, in any order, the unused code included.
  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_item(OP_W'($urandom_range(0, 3)), SIZE_W'($urandom));
  endtask

  task automatic run_phase(input bit with_full_table);
    int target;
    target = items_sent + PHASE_ITEMS;
    if (with_full_table) allocation_sequence(1'b1);
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 75)
        allocation_sequence(1'b0);
      else
        noise_burst();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_items();

    // Four pacing phases: free running, sender gaps, receiver stalls, and
    // both at once. Two of them also load a full table.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      run_phase(phase == 0 || phase == 3);
    end
    in_valid <= 1'b0;

    // Drain the replies still owed; the watchdog catches a reply that never
    // comes. Then allow one more full scan so that a stray late reply from a
    // dropped transaction would still be seen.
    while (replies_due != 0) @(negedge clk);
    repeat (MAX_BLOCKS + 8) @(negedge clk);

    if (mismatches == 0 && replies_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
